FILE: rtl/core/bgf_pkg.sv
package bgf_pkg;

    localparam int MAX_SIZE_DEF = 4096;
    localparam int CFG_SIZE_W   = 13;
    localparam int COORD_W      = 12;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 3;
    localparam int COLOR_W      = CH_W * NUM_CH;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = COLOR_W;
    localparam int IN_DATA_W    = 2 * COORD_W;
    localparam int OUT_DATA_W   = COLOR_W;

    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 4'd7;

    localparam logic MODE_TRIANGLE = 1'b0;
    localparam logic MODE_QUAD     = 1'b1;

    localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = 13'd64;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               use_bg;
        logic [COLOR_W-1:0] bg;
    } t_ctl;

    // channel 0 is red in the top byte
    function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] color,
                                             input int k);
        return color[(NUM_CH-1-k)*CH_W +: CH_W];
    endfunction

endpackage

FILE: rtl/core/bilinear_gradient_fill_core.sv
// 14 register stages: 5 weight stages, 8 divider stages, 1 output register
// throughput: one item per cycle; a stall at the output freezes the whole pipeline
// the quotient is formed one bit per stage by a restoring divider over W*H
// reset (i_rst_n low, synchronous): pipeline emptied, W = H = 64, quad mode,
// all colors 0
module bilinear_gradient_fill_core import bgf_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // pixel_x, pixel_y
    input  logic                  i_s_axis_tlast,  // end_of_span
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // red, green, blue
    output logic                  o_m_axis_tlast,  // span_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int DW = 2 * SW;
    localparam int NW = CH_W + 2 * SW;

    logic [CFG_SIZE_W-1:0] r_area_width, r_area_height;
    logic                  r_shape_mode;
    logic [COLOR_W-1:0]    r_c0, r_c1, r_c2, r_c3, r_bg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_width  <= SIZE_RESET;
            r_area_height <= SIZE_RESET;
            r_shape_mode  <= MODE_QUAD;
            r_c0          <= '0;
            r_c1          <= '0;
            r_c2          <= '0;
            r_c3          <= '0;
            r_bg          <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AREA_WIDTH:  r_area_width  <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_AREA_HEIGHT: r_area_height <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_SHAPE_MODE:  r_shape_mode  <= i_cfg_data[0];
                REG_CORNER_TL:   r_c0          <= i_cfg_data[COLOR_W-1:0];
                REG_CORNER_TR:   r_c1          <= i_cfg_data[COLOR_W-1:0];
                REG_CORNER_BL:   r_c2          <= i_cfg_data[COLOR_W-1:0];
                REG_CORNER_BR:   r_c3          <= i_cfg_data[COLOR_W-1:0];
                REG_BACKGROUND:  r_bg          <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    logic          en;
    t_ctl          w_ctl, d_ctl;
    logic [NW-1:0] w_num [NUM_CH];
    logic [DW-1:0] w_den;
    logic [CH_W-1:0] d_quo [NUM_CH];

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    bgf_weight #(.MAX_SIZE(MAX_SIZE)) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[COORD_W-1:0]),
        .i_y     (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_last  (i_s_axis_tlast),
        .i_cfg_w (r_area_width),
        .i_cfg_h (r_area_height),
        .i_mode  (r_shape_mode),
        .i_c0    (r_c0),
        .i_c1    (r_c1),
        .i_c2    (r_c2),
        .i_c3    (r_c3),
        .i_bg    (r_bg),
        .o_ctl   (w_ctl),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    bgf_div #(.MAX_SIZE(MAX_SIZE)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (w_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic [OUT_DATA_W-1:0] n_out_data;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_out_data[c*CH_W +: CH_W] = d_ctl.use_bg ? chan(d_ctl.bg, c) : d_quo[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_last <= d_ctl.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_valid_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !d_ctl.valid) |=> !o_m_axis_tvalid)
        else $error("output valid without divider item");

endmodule

FILE: rtl/core/bgf_weight.sv
module bgf_weight import bgf_pkg::*; #(
    parameter  int MAX_SIZE = MAX_SIZE_DEF,
    localparam int SW = $clog2(MAX_SIZE + 1),
    localparam int DW = 2 * SW,
    localparam int NW = CH_W + 2 * SW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [COORD_W-1:0]    i_x,
    input  logic [COORD_W-1:0]    i_y,
    input  logic                  i_last,
    input  logic [CFG_SIZE_W-1:0] i_cfg_w,
    input  logic [CFG_SIZE_W-1:0] i_cfg_h,
    input  logic                  i_mode,
    input  logic [COLOR_W-1:0]    i_c0,
    input  logic [COLOR_W-1:0]    i_c1,
    input  logic [COLOR_W-1:0]    i_c2,
    input  logic [COLOR_W-1:0]    i_c3,
    input  logic [COLOR_W-1:0]    i_bg,
    output t_ctl                  o_ctl,
    output logic [NW-1:0]         o_num [NUM_CH],
    output logic [DW-1:0]         o_den
);

    function automatic logic [SW-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end else if (32'(v) > MAX_SIZE) begin
            return SW'(MAX_SIZE);
        end else begin
            return SW'(v);
        end
    endfunction

    // stage 1: clamp and differences
    logic [SW-1:0] n1_w, n1_h, n1_x, n1_y;
    t_ctl          r1_ctl;
    logic [SW-1:0] r1_w, r1_h, r1_x, r1_y, r1_wmx, r1_hmy;
    logic [SW:0]   r1_xp1;

    always_comb begin
        n1_w = clamp_size(i_cfg_w);
        n1_h = clamp_size(i_cfg_h);
        n1_x = (32'(i_x) > 32'(n1_w)) ? n1_w : SW'(i_x);
        n1_y = (32'(i_y) > 32'(n1_h)) ? n1_h : SW'(i_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= '{valid: i_valid, last: i_last, use_bg: 1'b0, bg: i_bg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_w   <= n1_w;
            r1_h   <= n1_h;
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_wmx <= n1_w - n1_x;
            r1_hmy <= n1_h - n1_y;
            r1_xp1 <= {1'b0, n1_x} + (SW+1)'(1);
        end
    end

    // stage 2: corner weights, area, triangle edge terms
    t_ctl                 r2_ctl;
    logic [CH_W+SW-1:0]   r2_p0 [NUM_CH];
    logic [CH_W+SW-1:0]   r2_p1 [NUM_CH];
    logic [CH_W+SW-1:0]   r2_p2 [NUM_CH];
    logic [CH_W+SW-1:0]   r2_p3 [NUM_CH];
    logic [CH_W+SW-1:0]   r2_c2w [NUM_CH];
    logic [DW-1:0]        r2_den, r2_rhs;
    logic [DW:0]          r2_lhs;
    logic [SW-1:0]        r2_hmy, r2_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r2_p0[c]  <= chan(i_c0, c) * r1_wmx;
                r2_p1[c]  <= chan(i_c1, c) * r1_x;
                r2_p2[c]  <= chan(i_c2, c) * r1_wmx;
                r2_p3[c]  <= chan(i_c3, c) * r1_x;
                r2_c2w[c] <= chan(i_c2, c) * r1_w;
            end
            r2_den <= r1_w * r1_h;
            r2_lhs <= r1_xp1 * r1_h;
            r2_rhs <= r1_w * r1_hmy;
            r2_hmy <= r1_hmy;
            r2_y   <= r1_y;
        end
    end

    // stage 3: edge sums and inside test
    t_ctl                 r3_ctl;
    logic [CH_W+SW:0]     r3_top [NUM_CH];
    logic [CH_W+SW:0]     r3_opb [NUM_CH];
    logic                 r3_inside;
    logic [DW-1:0]        r3_den;
    logic [SW-1:0]        r3_hmy, r3_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_en) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r3_top[c] <= {1'b0, r2_p0[c]} + {1'b0, r2_p1[c]};
                r3_opb[c] <= (i_mode == MODE_QUAD) ? ({1'b0, r2_p2[c]} + {1'b0, r2_p3[c]})
                                                   : {1'b0, r2_c2w[c]};
            end
            r3_inside <= (r2_lhs <= {1'b0, r2_rhs});
            r3_den    <= r2_den;
            r3_hmy    <= r2_hmy;
            r3_y      <= r2_y;
        end
    end

    // stage 4: vertical weighting
    t_ctl                 r4_ctl;
    logic [NW-1:0]        r4_ta [NUM_CH];
    logic [NW-1:0]        r4_tb [NUM_CH];
    logic [DW-1:0]        r4_den;
    logic [CH_W+2*SW:0]   n4_ta [NUM_CH];
    logic [CH_W+2*SW:0]   n4_tb [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n4_ta[c] = r3_top[c] * r3_hmy;
            n4_tb[c] = r3_opb[c] * r3_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_en) begin
            r4_ctl <= '{valid: r3_ctl.valid, last: r3_ctl.last,
                        use_bg: (i_mode == MODE_TRIANGLE) && !r3_inside, bg: r3_ctl.bg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r4_ta[c] <= NW'(n4_ta[c]);
                r4_tb[c] <= NW'(n4_tb[c]);
            end
            r4_den <= r3_den;
        end
    end

    // stage 5: numerator
    t_ctl          r5_ctl;
    logic [NW-1:0] r5_num [NUM_CH];
    logic [DW-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (i_en) begin
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r5_num[c] <= r4_ta[c] + r4_tb[c];
            end
            r5_den <= r4_den;
        end
    end

    assign o_ctl = r5_ctl;
    assign o_num = r5_num;
    assign o_den = r5_den;

endmodule

FILE: rtl/core/bgf_div.sv
module bgf_div import bgf_pkg::*; #(
    parameter  int MAX_SIZE = MAX_SIZE_DEF,
    localparam int SW = $clog2(MAX_SIZE + 1),
    localparam int DW = 2 * SW,
    localparam int NW = CH_W + 2 * SW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_ctl            i_ctl,
    input  logic [NW-1:0]   i_num [NUM_CH],
    input  logic [DW-1:0]   i_den,
    output t_ctl            o_ctl,
    output logic [CH_W-1:0] o_quo [NUM_CH]
);

    // one quotient bit per stage, msb first
    t_ctl            r_ctl [CH_W];
    logic [DW-1:0]   r_den [CH_W];
    logic [NW-1:0]   r_rem [CH_W][NUM_CH];
    logic [CH_W-1:0] r_quo [CH_W][NUM_CH];

    for (genvar s = 0; s < CH_W; s++) begin : g_stage
        localparam int B = CH_W - 1 - s;
        localparam logic [CH_W-1:0] QBIT = CH_W'(1) << B;
        t_ctl            p_ctl;
        logic [DW-1:0]   p_den;
        logic [NW-1:0]   p_rem [NUM_CH];
        logic [CH_W-1:0] p_quo [NUM_CH];
        logic [NW-1:0]   trial;

        if (s == 0) begin : g_first
            assign p_ctl = i_ctl;
            assign p_den = i_den;
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign p_rem[c] = i_num[c];
                assign p_quo[c] = '0;
            end
        end else begin : g_next
            assign p_ctl = r_ctl[s-1];
            assign p_den = r_den[s-1];
            for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
                assign p_rem[c] = r_rem[s-1][c];
                assign p_quo[c] = r_quo[s-1][c];
            end
        end

        assign trial = NW'(p_den) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else if (i_en) begin
                r_ctl[s] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= p_den;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_quo[s][c] <= (p_rem[c] >= trial) ? (p_quo[c] | QBIT) : p_quo[c];
                    r_rem[s][c] <= (p_rem[c] >= trial) ? (p_rem[c] - trial) : p_rem[c];
                end
            end
        end
    end

    assign o_ctl = r_ctl[CH_W-1];
    assign o_quo = r_quo[CH_W-1];

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_ctl.valid))
        else $error("last divider stage changed during stall");

endmodule
